### hdl/pbd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the bounce direction block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pbd_pkg;

    // Material kind codes.
    localparam logic SURF_SPECULAR = 1'b0;
    localparam logic SURF_DIFFUSE  = 1'b1;

    // Configuration register index codes (taken from address bit 3).
    localparam logic REG_ROUGHNESS = 1'b0;
    localparam logic REG_RNG_SEED  = 1'b1;

    // Register reset values.
    localparam logic [14:0] ROUGHNESS_RESET = 15'd13107;
    localparam logic [47:0] RNG_SEED_RESET  = 48'd13070;

    // Linear congruential generator constants (modulus 2^48).
    localparam logic [34:0] LCG_MULT = 35'h5_DEEC_E66D;
    localparam logic [47:0] LCG_ADD  = 48'hB;

    // CORDIC constants; angles are in units of 2^-24 turn.
    localparam int unsigned         CORDIC_STEPS = 18;
    localparam logic signed [33:0]  CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [25:0]  TURN_QUARTER = 26'sd4194304;
    localparam logic signed [25:0]  TURN_HALF    = 26'sd8388608;
    localparam logic signed [25:0]  TURN_FULL    = 26'sd16777216;

    // First bit of the integer square root sweep.
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    // Queue between front and back.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = 1;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        logic             kind;
        logic [2:0][15:0] dir;
        logic [2:0][15:0] nrm;
        logic [2:0][31:0] hit;
        logic [33:0]      dot;
        logic [2:0][15:0] draw;
    } t_task;

    typedef enum logic [2:0] {
        F_IDLE,
        F_LO,
        F_HI,
        F_PUSH
    } t_fstate;

    typedef enum logic [5:0] {
        B_IDLE,
        SP_A, SP_B, SP_C,
        DF_W, DF_R2, DF_S3, DF_U,
        DV0, DV1, DV2,
        CO_INIT, CO_RUN, CO_END,
        DA, DB, DC,
        DT0, DT1, DT2, DT3,
        NM_SQ0, NM_SQ1, NM_SQ2, NM_SQ3, NM_LEN, NM_DIVI, NM_DIV, NM_DIVE,
        SQ_RUN,
        B_DONE
    } t_bstate;

    // Right shift that rounds half up (toward plus infinity).
    function automatic logic signed [65:0] rshift(input logic signed [65:0] v,
                                                  input int unsigned s);
        logic signed [65:0] bias;
        bias = (s == 0) ? 66'sd0 : (66'sd1 <<< (s - 1));
        return (s == 0) ? v : ((v + bias) >>> s);
    endfunction

    // atan(2^-i) in units of 2^-24 turn.
    function automatic logic signed [25:0] cordic_atan(input logic [4:0] i);
        logic signed [25:0] r;
        case (i)
            5'd0:    r = 26'sd2097152;
            5'd1:    r = 26'sd1238021;
            5'd2:    r = 26'sd654136;
            5'd3:    r = 26'sd332050;
            5'd4:    r = 26'sd166669;
            5'd5:    r = 26'sd83416;
            5'd6:    r = 26'sd41718;
            5'd7:    r = 26'sd20860;
            5'd8:    r = 26'sd10430;
            5'd9:    r = 26'sd5215;
            5'd10:   r = 26'sd2608;
            5'd11:   r = 26'sd1304;
            5'd12:   r = 26'sd652;
            5'd13:   r = 26'sd326;
            5'd14:   r = 26'sd163;
            5'd15:   r = 26'sd81;
            5'd16:   r = 26'sd41;
            5'd17:   r = 26'sd20;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/pbd_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, takes the random draws and forms the dot product.
// Depends on pbd_pkg.
module pbd_front import pbd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic         i_surface_kind,
    input  logic [15:0]  i_in_dir_x,
    input  logic [15:0]  i_in_dir_y,
    input  logic [15:0]  i_in_dir_z,
    input  logic [15:0]  i_normal_x,
    input  logic [15:0]  i_normal_y,
    input  logic [15:0]  i_normal_z,
    input  logic [31:0]  i_hit_x,
    input  logic [31:0]  i_hit_y,
    input  logic [31:0]  i_hit_z,
    input  logic         i_seed_load,
    input  logic [47:0]  i_seed,
    output logic         o_push,
    output t_task        o_task,
    input  logic         i_full
);

    t_fstate r_state, n_state;
    logic [47:0] r_gen;
    logic [47:0] r_plo;
    logic        r_kind;
    logic signed [15:0] r_dir [3];
    logic signed [15:0] r_nrm [3];
    logic [31:0] r_hit [3];
    logic [15:0] r_draw [3];
    logic signed [33:0] r_dot;
    logic [1:0]  r_cnt;
    logic [1:0]  r_dk;
    logic [47:0] gen_next;
    logic        accept;
    logic        last_draw;

    assign accept    = i_valid && !o_stall;
    assign last_draw = (r_kind == SURF_SPECULAR) ? (r_cnt == 2'd2) : (r_cnt == 2'd1);
    assign gen_next  = r_plo + ((48'(r_gen[47:24]) * 48'(LCG_MULT[23:0])) << 24) + LCG_ADD;

    // Next state and handshake outputs.
    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = F_LO;
                end
            end
            F_LO: n_state = F_HI;
            F_HI: n_state = last_draw ? F_PUSH : F_LO;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Generator state: a seed write reloads it, and each draw advances it in F_HI.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= RNG_SEED_RESET;
        end else if (i_seed_load) begin
            r_gen <= i_seed;
        end else if (r_state == F_HI) begin
            r_gen <= gen_next;
        end
    end

    // Item capture, draw storage and dot product accumulation.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_surface_kind;
            r_dir[0] <= i_in_dir_x;
            r_dir[1] <= i_in_dir_y;
            r_dir[2] <= i_in_dir_z;
            r_nrm[0] <= i_normal_x;
            r_nrm[1] <= i_normal_y;
            r_nrm[2] <= i_normal_z;
            r_hit[0] <= i_hit_x;
            r_hit[1] <= i_hit_y;
            r_hit[2] <= i_hit_z;
            r_dot    <= '0;
            r_cnt    <= '0;
            r_dk     <= '0;
        end
        if (r_state == F_LO) begin
            r_plo <= 48'(48'(r_gen[23:0]) * 48'(LCG_MULT));
        end
        if (r_state == F_HI) begin
            r_draw[r_cnt] <= gen_next[47:32];
            r_cnt         <= r_cnt + 2'd1;
        end
        if ((r_state == F_LO || r_state == F_HI) && r_dk != 2'd3) begin
            r_dot <= r_dot + 34'(r_nrm[r_dk] * r_dir[r_dk]);
            r_dk  <= r_dk + 2'd1;
        end
    end

    // Item handed to the queue.
    always_comb begin
        o_task.kind = r_kind;
        o_task.dot  = r_dot;
        for (int k = 0; k < 3; k++) begin
            o_task.dir[k]  = r_dir[k];
            o_task.nrm[k]  = r_nrm[k];
            o_task.hit[k]  = r_hit[k];
            o_task.draw[k] = r_draw[k];
        end
    end

endmodule

### hdl/pbd_queue.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and the back.
// Depends on pbd_pkg.
module pbd_queue import pbd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_task,
    output logic  o_empty
);

    t_task r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_task  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW + 1)'(i_push) - (Q_AW + 1)'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

endmodule

### hdl/pbd_back.sv
`timescale 1ns / 1ps
// Back end: sequencer that builds the bounce direction with one shared
// multiplier, an iterative square root, divider and CORDIC. Depends on pbd_pkg.
module pbd_back import pbd_pkg::*; #(
    parameter int unsigned DIR_FRAC_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_task        i_task,
    input  logic         i_empty,
    output logic         o_pop,
    input  logic [14:0]  i_roughness,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_origin_x,
    output logic [31:0]  o_origin_y,
    output logic [31:0]  o_origin_z,
    output logic [15:0]  o_out_dir_x,
    output logic [15:0]  o_out_dir_y,
    output logic [15:0]  o_out_dir_z
);

    localparam int unsigned F     = DIR_FRAC_BITS;
    localparam int unsigned VW    = 33;
    localparam int unsigned PW    = 66;
    localparam int unsigned QW    = F + 2;
    localparam int unsigned C_SHL = (F >= 16) ? F - 16 : 0;
    localparam int unsigned C_SHR = (F >= 16) ? 0 : 16 - F;
    localparam logic [QW-1:0] Q_ONE = QW'(1) << F;
    localparam logic [31:0]   F_ONE = 32'(1) << F;

    t_bstate r_state, n_state;
    t_bstate r_sret, r_nret;

    logic               r_kind;
    logic signed [15:0] r_d [3];
    logic signed [15:0] r_n [3];
    logic [31:0]        r_hit [3];
    logic signed [33:0] r_dot;
    logic [15:0]        r_draw [3];

    logic signed [VW-1:0] r_vec [3];
    logic signed [VW-1:0] r_nrm [3];
    logic signed [VW-1:0] r_u [3];
    logic signed [VW-1:0] r_v [3];
    logic signed [16:0]   r_w [3];
    logic signed [VW-1:0] r_refl;
    logic signed [VW-1:0] r_a, r_b, r_c;
    logic signed [VW-1:0] r_cs, r_sn;
    logic [16:0]          r_r2s;
    logic [1:0]           r_i;
    logic [4:0]           r_cnt;

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_acc;

    logic [63:0] r_sx, r_sres, r_sbit;
    logic [31:0] r_len;
    logic [63:0] r_rem, r_den;
    logic [QW-1:0] r_q;

    logic signed [33:0] r_x, r_y;
    logic signed [25:0] r_z;
    logic               r_neg;

    logic               r_ovalid;
    logic [31:0]        r_oorg [3];
    logic [15:0]        r_odir [3];

    logic signed [VW-1:0] ma, mb;
    logic [1:0]  nx1, nx2;
    logic        last_i;
    logic        out_free;
    logic [63:0] sq_try;
    logic [32:0] mag_j;
    logic [QW-1:0] q_clamp;
    logic [23:0] angle;
    logic signed [25:0] z_wrap;
    logic signed [33:0] cx_adj, cy_adj;
    logic signed [VW-1:0] sign_w0;
    logic [20:0] w0_mag10;

    assign nx1      = (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
    assign nx2      = (r_i == 2'd0) ? 2'd2 : r_i - 2'd1;
    assign last_i   = (r_i == 2'd2);
    assign out_free = !r_ovalid || !i_stall;
    assign sq_try   = r_sres + r_sbit;
    assign mag_j    = r_vec[r_i][VW-1] ? 33'(-r_vec[r_i]) : 33'(r_vec[r_i]);
    assign q_clamp  = (r_q > Q_ONE) ? Q_ONE : r_q;
    assign angle    = {r_draw[0], 8'd0};
    assign z_wrap   = ($signed({2'b00, angle}) >= TURN_HALF) ?
                      $signed({2'b00, angle}) - TURN_FULL : $signed({2'b00, angle});
    assign cx_adj   = r_neg ? -r_x : r_x;
    assign cy_adj   = r_neg ? -r_y : r_y;
    assign sign_w0  = VW'(r_w[0]);
    assign w0_mag10 = 21'(sign_w0[VW-1] ? 17'(-r_w[0]) : 17'(r_w[0])) * 21'd10;

    // Next state, multiplier operand selection and queue pop.
    always_comb begin
        n_state = r_state;
        ma      = '0;
        mb      = '0;
        o_pop   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = (i_task.kind == SURF_SPECULAR) ? SP_A : DF_W;
                end
            end
            SP_A: begin
                ma      = VW'(r_n[r_i]);
                mb      = VW'(r_dot);
                n_state = SP_B;
            end
            SP_B: begin
                ma      = VW'($signed({1'b0, r_draw[r_i]}) - 17'sd32768);
                mb      = VW'($signed({1'b0, i_roughness}));
                n_state = SP_C;
            end
            SP_C:    n_state = last_i ? NM_SQ0 : SP_A;
            DF_W:    n_state = SQ_RUN;
            DF_R2:   n_state = SQ_RUN;
            DF_S3:   n_state = NM_SQ0;
            DF_U:    n_state = DV0;
            DV0: begin
                ma      = VW'(r_w[nx1]);
                mb      = r_u[nx2];
                n_state = DV1;
            end
            DV1: begin
                ma      = VW'(r_w[nx2]);
                mb      = r_u[nx1];
                n_state = DV2;
            end
            DV2:     n_state = last_i ? CO_INIT : DV0;
            CO_INIT: n_state = CO_RUN;
            CO_RUN:  n_state = (r_cnt == 5'(CORDIC_STEPS - 1)) ? CO_END : CO_RUN;
            CO_END:  n_state = DA;
            DA: begin
                ma      = r_cs;
                mb      = VW'($signed({1'b0, r_r2s}));
                n_state = DB;
            end
            DB: begin
                ma      = r_sn;
                mb      = VW'($signed({1'b0, r_r2s}));
                n_state = DC;
            end
            DC:      n_state = DT0;
            DT0: begin
                ma      = r_u[r_i];
                mb      = r_a;
                n_state = DT1;
            end
            DT1: begin
                ma      = r_v[r_i];
                mb      = r_b;
                n_state = DT2;
            end
            DT2: begin
                ma      = VW'(r_w[r_i]);
                mb      = r_c;
                n_state = DT3;
            end
            DT3:     n_state = last_i ? NM_SQ0 : DT0;
            NM_SQ0: begin
                ma      = r_vec[0];
                mb      = r_vec[0];
                n_state = NM_SQ1;
            end
            NM_SQ1: begin
                ma      = r_vec[1];
                mb      = r_vec[1];
                n_state = NM_SQ2;
            end
            NM_SQ2: begin
                ma      = r_vec[2];
                mb      = r_vec[2];
                n_state = NM_SQ3;
            end
            NM_SQ3:  n_state = SQ_RUN;
            NM_LEN:  n_state = NM_DIVI;
            NM_DIVI: n_state = (r_len == '0) ? NM_DIVE : NM_DIV;
            NM_DIV:  n_state = (r_cnt == '0) ? NM_DIVE : NM_DIV;
            NM_DIVE: n_state = last_i ? r_nret : NM_DIVI;
            SQ_RUN:  n_state = (r_cnt == 5'd31) ? r_sret : SQ_RUN;
            B_DONE:  n_state = out_free ? B_IDLE : B_DONE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register: loaded when the result is done, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == B_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_DONE && out_free) begin
            for (int k = 0; k < 3; k++) begin
                r_oorg[k] <= r_hit[k];
                r_odir[k] <= r_nrm[k][15:0];
            end
        end
    end

    // Datapath registers, one step per state.
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(ma) * PW'(mb);
        case (r_state)
            B_IDLE: begin
                r_kind <= i_task.kind;
                r_dot  <= $signed(i_task.dot);
                for (int k = 0; k < 3; k++) begin
                    r_d[k]    <= $signed(i_task.dir[k]);
                    r_n[k]    <= $signed(i_task.nrm[k]);
                    r_hit[k]  <= i_task.hit[k];
                    r_draw[k] <= i_task.draw[k];
                end
                r_i    <= '0;
                r_nret <= B_DONE;
            end
            SP_B: r_refl <= VW'(rshift(r_prod <<< 1, 2 * F));
            SP_C: begin
                r_vec[r_i] <= VW'(r_d[r_i]) - r_refl + VW'(rshift(r_prod, 16));
                r_i        <= last_i ? 2'd0 : r_i + 2'd1;
            end
            // Diffuse: flip the normal toward the incoming side, then sqrt(r2).
            DF_W: begin
                for (int k = 0; k < 3; k++) begin
                    r_w[k] <= (r_dot < 0) ? 17'(r_n[k]) : -17'(r_n[k]);
                end
                r_sx   <= {32'd0, r_draw[1], 16'd0};
                r_sres <= '0;
                r_sbit <= SQRT_BIT0;
                r_cnt  <= '0;
                r_sret <= DF_R2;
            end
            DF_R2: begin
                r_r2s  <= r_sres[16:0];
                r_sx   <= {31'd0, 17'h1_0000 - {1'b0, r_draw[1]}, 16'd0};
                r_sres <= '0;
                r_sbit <= SQRT_BIT0;
                r_cnt  <= '0;
                r_sret <= DF_S3;
            end
            // Height term and the helper axis crossed with the normal.
            DF_S3: begin
                r_c <= VW'(rshift(PW'($signed({1'b0, r_sres[16:0]})) <<< C_SHL, C_SHR));
                if (32'(w0_mag10) > F_ONE) begin
                    r_vec[0] <= VW'(r_w[2]);
                    r_vec[1] <= '0;
                    r_vec[2] <= -VW'(r_w[0]);
                end else begin
                    r_vec[0] <= '0;
                    r_vec[1] <= -VW'(r_w[2]);
                    r_vec[2] <= VW'(r_w[1]);
                end
                r_nret <= DF_U;
            end
            // The second normalization ends the item.
            DF_U: begin
                for (int k = 0; k < 3; k++) begin
                    r_u[k] <= r_nrm[k];
                end
                r_i    <= '0;
                r_nret <= B_DONE;
            end
            DV1: r_acc <= r_prod;
            DV2: begin
                r_v[r_i] <= VW'(rshift(r_acc - r_prod, F));
                r_i      <= last_i ? 2'd0 : r_i + 2'd1;
            end
            // CORDIC set-up: wrap the angle to a half turn and fold the outer quarters.
            CO_INIT: begin
                r_x   <= CORDIC_GAIN;
                r_y   <= '0;
                r_cnt <= '0;
                if (z_wrap > TURN_QUARTER) begin
                    r_z   <= z_wrap - TURN_HALF;
                    r_neg <= 1'b1;
                end else if (z_wrap < -TURN_QUARTER) begin
                    r_z   <= z_wrap + TURN_HALF;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= z_wrap;
                    r_neg <= 1'b0;
                end
            end
            CO_RUN: begin
                if (r_z >= 0) begin
                    r_x <= r_x - (r_y >>> r_cnt);
                    r_y <= r_y + (r_x >>> r_cnt);
                    r_z <= r_z - cordic_atan(r_cnt);
                end else begin
                    r_x <= r_x + (r_y >>> r_cnt);
                    r_y <= r_y - (r_x >>> r_cnt);
                    r_z <= r_z + cordic_atan(r_cnt);
                end
                r_cnt <= r_cnt + 5'd1;
            end
            CO_END: begin
                r_cs <= VW'(rshift(PW'(cx_adj), 30 - F));
                r_sn <= VW'(rshift(PW'(cy_adj), 30 - F));
            end
            DB: r_a <= VW'(rshift(r_prod, 16));
            DC: begin
                r_b <= VW'(rshift(r_prod, 16));
                r_i <= '0;
            end
            DT1: r_acc <= r_prod;
            DT2: r_acc <= r_acc + r_prod;
            DT3: begin
                r_vec[r_i] <= VW'(rshift(r_acc + r_prod, F));
                r_i        <= last_i ? 2'd0 : r_i + 2'd1;
            end
            // Normalization: sum of squares, square root, then one divide per axis.
            NM_SQ1: r_acc <= r_prod;
            NM_SQ2: r_acc <= r_acc + r_prod;
            NM_SQ3: begin
                r_sx   <= 64'(r_acc + r_prod);
                r_sres <= '0;
                r_sbit <= SQRT_BIT0;
                r_cnt  <= '0;
                r_sret <= NM_LEN;
            end
            NM_LEN: begin
                r_len <= r_sres[31:0];
                r_i   <= '0;
            end
            NM_DIVI: begin
                r_rem <= (64'(mag_j) << F) + 64'(r_len >> 1);
                r_den <= 64'(r_len) << (F + 1);
                r_q   <= '0;
                r_cnt <= 5'(F + 1);
            end
            NM_DIV: begin
                if (r_rem >= r_den) begin
                    r_rem <= r_rem - r_den;
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_den <= r_den >> 1;
                r_cnt <= r_cnt - 5'd1;
            end
            NM_DIVE: begin
                if (r_len == '0) begin
                    r_nrm[r_i] <= '0;
                end else if (r_vec[r_i] < 0) begin
                    r_nrm[r_i] <= -VW'($signed({1'b0, q_clamp}));
                end else begin
                    r_nrm[r_i] <= VW'($signed({1'b0, q_clamp}));
                end
                r_i <= last_i ? 2'd0 : r_i + 2'd1;
            end
            // Integer square root, one result bit per cycle.
            SQ_RUN: begin
                if (r_sx >= sq_try) begin
                    r_sx   <= r_sx - sq_try;
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
                r_cnt  <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_origin_x  = r_oorg[0];
    assign o_origin_y  = r_oorg[1];
    assign o_origin_z  = r_oorg[2];
    assign o_out_dir_x = r_odir[0];
    assign o_out_dir_y = r_odir[1];
    assign o_out_dir_z = r_odir[2];

`ifndef SYNTHESIS
    // A component never exceeds one unit before clamping.
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == NM_DIVE && r_len != '0) |-> (r_q <= Q_ONE))
        else $error("normalize quotient above one");

    // The reflection path only runs on specular items.
    a_spec_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SP_A) |-> (r_kind == SURF_SPECULAR))
        else $error("specular path on a diffuse item");

    // The hemisphere path only runs on diffuse items.
    a_diff_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DF_R2) |-> (r_kind == SURF_DIFFUSE))
        else $error("diffuse path on a specular item");
`endif

endmodule

### hdl/path_trace_bounce_direction_core.sv
`timescale 1ns / 1ps
// Top level of the bounce direction block: configuration registers and the
// front, queue and back. Depends on pbd_pkg, pbd_front, pbd_queue, pbd_back.
//
// Usage: an item (surface kind, incoming direction, normal, hit point) is
// accepted when i_valid is high and o_stall is low. One ray comes back per
// item on o_valid/i_stall with the hit point as origin and a unit direction.
// The front takes the random draws, one 48-bit generator step per draw,
// three for a specular item and two for a diffuse one, then hands it on.
// A two-entry queue lets the front take new items while the back works.
// The back is a sequencer on one shared multiplier with a bit-serial square
// root, an 18-step CORDIC and an (F+2)-bit divide per axis (F the number of
// fraction bits); it works on one item at a time and so sets the rate.
// A finished ray waits in the output register while the receiver stalls;
// the back then holds, the queue fills and o_stall rises. Reset empties all
// stages and loads roughness 0.8 and the seed value into the generator.
// Registers: roughness at byte address 0, seed at 8 (writing it reloads the
// generator). Write only while the block is idle.
module path_trace_bounce_direction_core import pbd_pkg::*; #(
    parameter int unsigned DIR_FRAC_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic         i_surface_kind,
    input  logic [15:0]  i_in_dir_x,
    input  logic [15:0]  i_in_dir_y,
    input  logic [15:0]  i_in_dir_z,
    input  logic [15:0]  i_normal_x,
    input  logic [15:0]  i_normal_y,
    input  logic [15:0]  i_normal_z,
    input  logic [31:0]  i_hit_x,
    input  logic [31:0]  i_hit_y,
    input  logic [31:0]  i_hit_z,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_origin_x,
    output logic [31:0]  o_origin_y,
    output logic [31:0]  o_origin_z,
    output logic [15:0]  o_out_dir_x,
    output logic [15:0]  o_out_dir_y,
    output logic [15:0]  o_out_dir_z
);

    logic [14:0] r_roughness;
    logic [47:0] r_rng_seed;
    logic        cfg_wr;
    logic        seed_load;
    logic        push, pop, full, empty;
    t_task       front_task, head_task;

    // Register decode uses address bit 3 as the register index.
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign seed_load = cfg_wr && (paddr[3] == REG_RNG_SEED);
    assign prdata    = (paddr[3] == REG_RNG_SEED) ? 64'(r_rng_seed) : 64'(r_roughness);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roughness <= ROUGHNESS_RESET;
            r_rng_seed  <= RNG_SEED_RESET;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_ROUGHNESS) begin
                r_roughness <= pwdata[14:0];
            end else begin
                r_rng_seed  <= pwdata[47:0];
            end
        end
    end

    pbd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_surface_kind (i_surface_kind),
        .i_in_dir_x     (i_in_dir_x),
        .i_in_dir_y     (i_in_dir_y),
        .i_in_dir_z     (i_in_dir_z),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_hit_x        (i_hit_x),
        .i_hit_y        (i_hit_y),
        .i_hit_z        (i_hit_z),
        .i_seed_load    (seed_load),
        .i_seed         (pwdata[47:0]),
        .o_push         (push),
        .o_task         (front_task),
        .i_full         (full)
    );

    pbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (front_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_task  (head_task),
        .o_empty (empty)
    );

    pbd_back #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_task      (head_task),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_roughness (r_roughness),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_origin_x  (o_origin_x),
        .o_origin_y  (o_origin_y),
        .o_origin_z  (o_origin_z),
        .o_out_dir_x (o_out_dir_x),
        .o_out_dir_y (o_out_dir_y),
        .o_out_dir_z (o_out_dir_z)
    );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the bounce direction block: directed and random
// rays through its handshakes, checked against a built-in bounce predictor.
// Depends on pbd_pkg and path_trace_bounce_direction_core.
module tb;
    import pbd_pkg::*;

    localparam int F = 14;
    localparam logic [3:0] ADDR_ROUGH = 4'd0;
    localparam logic [3:0] ADDR_SEED  = 4'd8;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [31:0] ox, oy, oz;
        logic [15:0] dx, dy, dz;
    } ray_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic pready;
    logic i_valid = 0, i_stall = 0;
    logic o_stall, o_valid;
    logic i_surface_kind = 0;
    logic [15:0] i_in_dir_x = 0, i_in_dir_y = 0, i_in_dir_z = 0;
    logic [15:0] i_normal_x = 0, i_normal_y = 0, i_normal_z = 0;
    logic [31:0] i_hit_x = 0, i_hit_y = 0, i_hit_z = 0;
    logic [31:0] o_origin_x, o_origin_y, o_origin_z;
    logic [15:0] o_out_dir_x, o_out_dir_y, o_out_dir_z;

    path_trace_bounce_direction_core dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state mirrors the block's registers and generator.
    logic [14:0] pred_rough;
    logic [47:0] pred_gen;
    ray_t expected_rays[$];
    int errors = 0;
    int rays_checked = 0;
    int n_spec = 0, n_diff = 0;
    longint cycles = 0;
    bit stall_quiet = 0;

    // Cycle limit guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint gen_draw();
        pred_gen = pred_gen * 48'h5_DEEC_E66D + 48'hB;
        return longint'(pred_gen[47:32]);
    endfunction

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // Unit vector with the rounding and clamping of the block.
    task automatic unit_vec(input longint v[3], output longint o[3]);
        longint unsigned sum, len, q;
        sum = 0;
        for (int i = 0; i < 3; i++) sum += absval(v[i]) * absval(v[i]);
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                o[i] = 0;
            end else begin
                q = ((absval(v[i]) << F) + len / 2) / len;
                if (q > (64'd1 << F)) q = 64'd1 << F;
                o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
        end
    endtask

    // CORDIC sine and cosine of an angle in 2^-24 turns.
    task automatic turn_sincos(input longint ang, output longint c, output longint s);
        longint x, y, z, nx;
        bit neg;
        x = 652032874;
        y = 0;
        neg = 0;
        z = ang >= 8388608 ? ang - 16777216 : ang;
        if (z > 4194304) begin
            z -= 8388608;
            neg = 1;
        end else if (z < -4194304) begin
            z += 8388608;
            neg = 1;
        end
        for (int i = 0; i < 18; i++) begin
            if (z >= 0) begin
                nx = x - fshift(y, i);
                y = y + fshift(x, i);
                z -= longint'(cordic_atan(5'(i)));
            end else begin
                nx = x + fshift(y, i);
                y = y - fshift(x, i);
                z += longint'(cordic_atan(5'(i)));
            end
            x = nx;
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        c = rnd_shift(x, 30 - F);
        s = rnd_shift(y, 30 - F);
    endtask

    // Bounce direction of one ray.
    task automatic predict_bounce(input logic kind, input logic [15:0] din[3],
                                  input logic [15:0] nin[3], output longint o[3]);
        longint d[3], n[3], r[3], w[3], ax[3], u[3], v[3], t[3];
        longint dot, cs, sn, a, b, c, jit;
        longint unsigned u1, u2, r2s, s3;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(din[i]));
            n[i] = longint'($signed(nin[i]));
        end
        dot = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
        if (kind == SURF_SPECULAR) begin
            for (int i = 0; i < 3; i++) begin
                jit = rnd_shift((gen_draw() - 32768) * longint'(pred_rough), 16);
                r[i] = d[i] - rnd_shift(2 * n[i] * dot, 2 * F) + jit;
            end
            unit_vec(r, o);
        end else begin
            for (int i = 0; i < 3; i++) w[i] = dot < 0 ? n[i] : -n[i];
            u1 = gen_draw();
            u2 = gen_draw();
            r2s = int_sqrt(u2 << 16);
            s3 = int_sqrt((64'd65536 - u2) << 16);
            if (absval(w[0]) * 10 > (64'd1 << F)) begin
                ax[0] = w[2]; ax[1] = 0; ax[2] = -w[0];
            end else begin
                ax[0] = 0; ax[1] = -w[2]; ax[2] = w[1];
            end
            unit_vec(ax, u);
            v[0] = rnd_shift(w[1] * u[2] - w[2] * u[1], F);
            v[1] = rnd_shift(w[2] * u[0] - w[0] * u[2], F);
            v[2] = rnd_shift(w[0] * u[1] - w[1] * u[0], F);
            turn_sincos(longint'(u1 << 8), cs, sn);
            a = rnd_shift(cs * longint'(r2s), 16);
            b = rnd_shift(sn * longint'(r2s), 16);
            c = rnd_shift(longint'(s3), 16 - F);
            for (int i = 0; i < 3; i++)
                t[i] = rnd_shift(u[i] * a + v[i] * b + w[i] * c, F);
            unit_vec(t, o);
        end
    endtask

    // Register write over the APB port; the block must be idle.
    task automatic write_reg(input logic [3:0] addr, input logic [63:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == ADDR_ROUGH) begin
            pred_rough = val[14:0];
        end else begin
            pred_gen = val[47:0];
        end
        @(posedge i_clk);
    endtask

    // Send one item after a random gap, or none if no_gap is set, and queue its expected ray.
    // Valid stays high after acceptance so that a following item can go
    // back to back; a gap or the drain drops it.
    task automatic send_ray(input logic kind, input logic [15:0] d[3],
                            input logic [15:0] n[3], input logic [31:0] h[3],
                            input bit no_gap);
        longint o[3];
        ray_t r;
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_surface_kind <= kind;
        i_in_dir_x <= d[0]; i_in_dir_y <= d[1]; i_in_dir_z <= d[2];
        i_normal_x <= n[0]; i_normal_y <= n[1]; i_normal_z <= n[2];
        i_hit_x <= h[0]; i_hit_y <= h[1]; i_hit_z <= h[2];
        predict_bounce(kind, d, n, o);
        r.ox = h[0]; r.oy = h[1]; r.oz = h[2];
        r.dx = o[0][15:0]; r.dy = o[1][15:0]; r.dz = o[2][15:0];
        expected_rays.push_back(r);
        if (kind == SURF_SPECULAR) n_spec++; else n_diff++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Receiver stall, drawn per result.
    initial begin
        int w;
        forever begin
            @(posedge i_clk);
            if (stall_quiet) begin
                i_stall <= 0;
            end else if (o_valid && !i_stall) begin
                w = $urandom_range(0, 12);
                if (w > 0) begin
                    i_stall <= 1;
                    repeat (w) @(posedge i_clk);
                    i_stall <= 0;
                end
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        ray_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rays.size() == 0) begin
                $error("ray with no expectation waiting");
                errors++;
            end else begin
                e = expected_rays.pop_front();
                rays_checked++;
                if (o_origin_x !== e.ox) begin
                    $error("origin_x exp %h got %h", e.ox, o_origin_x); errors++;
                end
                if (o_origin_y !== e.oy) begin
                    $error("origin_y exp %h got %h", e.oy, o_origin_y); errors++;
                end
                if (o_origin_z !== e.oz) begin
                    $error("origin_z exp %h got %h", e.oz, o_origin_z); errors++;
                end
                if (o_out_dir_x !== e.dx) begin
                    $error("out_dir_x exp %h got %h", e.dx, o_out_dir_x); errors++;
                end
                if (o_out_dir_y !== e.dy) begin
                    $error("out_dir_y exp %h got %h", e.dy, o_out_dir_y); errors++;
                end
                if (o_out_dir_z !== e.dz) begin
                    $error("out_dir_z exp %h got %h", e.dz, o_out_dir_z); errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 0;
        while (expected_rays.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Random unit-ish vector: mostly normalized, some raw 16-bit noise.
    task automatic rand_vec(output logic [15:0] v[3]);
        longint r[3], o[3];
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 3; i++) v[i] = 16'($urandom);
        end else begin
            for (int i = 0; i < 3; i++) r[i] = $signed(16'($urandom));
            unit_vec(r, o);
            for (int i = 0; i < 3; i++) v[i] = o[i][15:0];
        end
    endtask

    task automatic test_directed();
        logic [15:0] d[3], n[3], z[3], mx[3], mn[3];
        logic [31:0] h[3], hmax[3], hmin[3];
        z = '{16'h0, 16'h0, 16'h0};
        mx = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
        mn = '{16'h8000, 16'h8000, 16'h8000};
        hmax = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        hmin = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        h = '{32'h0001_0000, 32'hFFFF_0000, 32'h0};
        d = '{16'h0, 16'hC000, 16'h0};
        n = '{16'h0, 16'h4000, 16'h0};
        for (int k = 0; k < 2; k++) begin
            logic kk;
            kk = k[0];
            send_ray(kk, d, n, h, 0);
            send_ray(kk, d, '{16'h0, 16'hC000, 16'h0}, hmax, 0);
            send_ray(kk, mx, mx, hmin, 0);
            send_ray(kk, mn, mn, hmax, 0);
            send_ray(kk, mx, mn, h, 0);
            send_ray(kk, z, z, h, 0);
            send_ray(kk, d, '{16'h4000, 16'h0, 16'h0}, h, 0);
            send_ray(kk, d, '{16'h0600, 16'h0, 16'h3F00}, h, 0);
        end
        wait_drained();
        // Zero roughness makes the specular mirror exact; zero-length case.
        write_reg(ADDR_ROUGH, 64'd0);
        send_ray(SURF_SPECULAR, z, z, h, 0);
        send_ray(SURF_SPECULAR, d, n, h, 0);
        wait_drained();
        write_reg(ADDR_ROUGH, 64'h7FFF);
        send_ray(SURF_SPECULAR, d, n, h, 0);
        send_ray(SURF_SPECULAR, mx, z, hmax, 0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [15:0] d[3], n[3];
        logic [31:0] h[3];
        for (int i = 0; i < count; i++) begin
            rand_vec(d);
            rand_vec(n);
            for (int j = 0; j < 3; j++) h[j] = $urandom;
            send_ray(1'($urandom), d, n, h, (i % 200) > 150);
            stall_quiet = (i % 300) > 250;
        end
        stall_quiet = 0;
        wait_drained();
    endtask

    initial begin
        pred_rough = ROUGHNESS_RESET;
        pred_gen = RNG_SEED_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        write_reg(ADDR_ROUGH, 64'd16384);
        write_reg(ADDR_SEED, 64'hFFFF_FFFF_FFFF);
        test_random(300);
        write_reg(ADDR_ROUGH, 64'($urandom_range(0, 32767)));
        write_reg(ADDR_SEED, 64'd0);
        test_random(300);
        write_reg(ADDR_ROUGH, 64'd13107);
        write_reg(ADDR_SEED, {16'($urandom), 32'($urandom)});
        test_random(620);
        $display("Checked %0d rays (%0d specular, %0d diffuse) over four settings.",
                 rays_checked, n_spec, n_diff);
        if (errors == 0 && expected_rays.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
